// ===== rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: word widths, internal widths, queue depth,
// result kind codes, the job word passed from front to back, and helper functions.
// No dependencies.
package qrs_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Magnitude of b*b - 4*a*c stays below 2^(2*WORD_BITS+1).
	localparam int DMAG_BITS = 2 * WORD_BITS + 1;
	localparam int ROOT_BITS = WORD_BITS + 1;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int SREM_BITS = ROOT_BITS + 3;
	localparam int NUM_BITS  = WORD_BITS + 2;
	localparam int QUO_BITS  = NUM_BITS + FRAC_BITS;
	localparam int DEN_BITS  = WORD_BITS + 1;
	localparam int DREM_BITS = WORD_BITS + 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [QUO_BITS-1:0]  Q_HALF   = QUO_BITS'(1) << (WORD_BITS - 1);
	localparam logic [QUO_BITS-1:0]  Q_MAXP   = Q_HALF - QUO_BITS'(1);

	typedef enum logic [1:0] {
		KIND_DISTINCT = 2'd0,
		KIND_REPEATED = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_DEGEN    = 2'd3
	} kind_t;

	// Classified equation handed from the front end to the solver back end.
	typedef struct packed {
		kind_t                 kind;
		logic                  an;
		logic [WORD_BITS-1:0]  am;
		logic                  mbneg;
		logic [WORD_BITS-1:0]  bm;
		logic [DMAG_BITS-1:0]  dmag;
	} job_t;

	typedef struct packed {
		logic                 neg;
		logic [NUM_BITS-1:0]  mag;
	} sm_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] val;
		logic                 sat;
	} fin_t;

	// Sign-magnitude addition; an exact zero from operands of opposite sign comes out positive.
	function automatic sm_t sm_add(input logic xn, input logic [NUM_BITS-1:0] xm,
			input logic yn, input logic [NUM_BITS-1:0] ym);
		sm_t r;
		if (xn == yn) begin
			r.neg = xn;
			r.mag = xm + ym;
		end else if (xm == ym) begin
			r.neg = 1'b0;
			r.mag = '0;
		end else if (xm > ym) begin
			r.neg = xn;
			r.mag = xm - ym;
		end else begin
			r.neg = yn;
			r.mag = ym - xm;
		end
		return r;
	endfunction

	// Applies the sign to a quotient magnitude and clips it to the word range.
	function automatic fin_t finish(input logic [QUO_BITS-1:0] q, input logic nneg,
			input logic an);
		fin_t r;
		logic neg;
		logic [QUO_BITS-1:0] tmp;
		neg   = (nneg != an) && (q != '0);
		tmp   = ~q + QUO_BITS'(1);
		r.sat = 1'b0;
		if (neg) begin
			if (q > Q_HALF) begin
				r.val = WORD_MIN;
				r.sat = 1'b1;
			end else begin
				r.val = tmp[WORD_BITS-1:0];
			end
		end else if (q > Q_MAXP) begin
			r.val = WORD_MAX;
			r.sat = 1'b1;
		end else begin
			r.val = q[WORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/qrs_if.sv =====
// Handshake interfaces for the coefficient and root channels.
// Depends on qrs_pkg.
interface qrs_in_if;
	import qrs_pkg::*;
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] coeff_a;
	logic signed [WORD_BITS-1:0] coeff_b;
	logic signed [WORD_BITS-1:0] coeff_c;
	modport source(output valid, coeff_a, coeff_b, coeff_c, input ready);
	modport sink(input valid, coeff_a, coeff_b, coeff_c, output ready);
endinterface

interface qrs_out_if;
	import qrs_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  root_kind;
	logic signed [WORD_BITS-1:0] first_value;
	logic signed [WORD_BITS-1:0] second_value;
	logic                        saturated;
	modport source(output valid, root_kind, first_value, second_value, saturated, input ready);
	modport sink(input valid, root_kind, first_value, second_value, saturated, output ready);
endinterface

// ===== rtl/qrs_front.sv =====
// Front end: takes coefficient words, forms magnitudes, the discriminant and the kind.
// Depends on qrs_pkg and qrs_if.
module qrs_front (
	input  logic          clk,
	input  logic          arst_n,
	qrs_in_if.sink        coeffs,
	output qrs_pkg::job_t job,
	output logic          job_valid,
	input  logic          job_ready
);
	import qrs_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic [WORD_BITS-1:0] a_raw, b_raw, c_raw, am, bm, cm;

	logic                   an_s1, bn_s1, cn_s1;
	logic [WORD_BITS-1:0]   am_s1, bm_s1, cm_s1;

	logic                   an_s2, mbneg_s2, sub_s2, azero_s2;
	logic [WORD_BITS-1:0]   am_s2, bm_s2;
	logic [2*WORD_BITS-1:0] b2_s2, ac_s2;

	logic [DMAG_BITS-1:0]   ac4, b2x, dmag;
	logic                   dneg;
	job_t                   job_s3, job_nx;

	assign adv          = !v_s3 || job_ready;
	assign coeffs.ready = adv;
	assign job          = job_s3;
	assign job_valid    = v_s3;

	assign a_raw = coeffs.coeff_a;
	assign b_raw = coeffs.coeff_b;
	assign c_raw = coeffs.coeff_c;
	assign am = a_raw[WORD_BITS-1] ? (~a_raw + WORD_BITS'(1)) : a_raw;
	assign bm = b_raw[WORD_BITS-1] ? (~b_raw + WORD_BITS'(1)) : b_raw;
	assign cm = c_raw[WORD_BITS-1] ? (~c_raw + WORD_BITS'(1)) : c_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= coeffs.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// 4ac is b*b's partner; when signs of a and c agree it is subtracted.
	always_comb begin
		ac4 = {ac_s2[2*WORD_BITS-2:0], 2'b00};
		b2x = {1'b0, b2_s2};
		if (!sub_s2) begin
			dmag = b2x + ac4;
			dneg = 1'b0;
		end else if (b2x >= ac4) begin
			dmag = b2x - ac4;
			dneg = 1'b0;
		end else begin
			dmag = ac4 - b2x;
			dneg = 1'b1;
		end
		job_nx.an    = an_s2;
		job_nx.am    = am_s2;
		job_nx.mbneg = mbneg_s2;
		job_nx.bm    = bm_s2;
		job_nx.dmag  = dmag;
		if (azero_s2) begin
			job_nx.kind = KIND_DEGEN;
		end else if (dmag == '0) begin
			job_nx.kind = KIND_REPEATED;
		end else if (dneg) begin
			job_nx.kind = KIND_COMPLEX;
		end else begin
			job_nx.kind = KIND_DISTINCT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			an_s1    <= a_raw[WORD_BITS-1];
			bn_s1    <= b_raw[WORD_BITS-1];
			cn_s1    <= c_raw[WORD_BITS-1];
			am_s1    <= am;
			bm_s1    <= bm;
			cm_s1    <= cm;
			b2_s2    <= (2*WORD_BITS)'(bm_s1) * (2*WORD_BITS)'(bm_s1);
			ac_s2    <= (2*WORD_BITS)'(am_s1) * (2*WORD_BITS)'(cm_s1);
			an_s2    <= an_s1;
			am_s2    <= am_s1;
			bm_s2    <= bm_s1;
			mbneg_s2 <= !bn_s1 && (bm_s1 != '0);
			sub_s2   <= (an_s1 == cn_s1);
			azero_s2 <= (am_s1 == '0);
			job_s3   <= job_nx;
		end
	end

endmodule

// ===== rtl/qrs_fifo.sv =====
// Short queue between front end and back end.
// Depends on qrs_pkg.
module qrs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  qrs_pkg::job_t push_data,
	input  logic          push_valid,
	output logic          push_ready,
	output qrs_pkg::job_t pop_data,
	output logic          pop_valid,
	input  logic          pop_ready
);
	import qrs_pkg::*;

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push, pop;

	assign push_ready = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + FIFO_AW'(1);
			if (pop)  rd_q <= rd_q + FIFO_AW'(1);
			if (push && !pop) cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (FIFO_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// ===== rtl/qrs_back.sv =====
// Back end: pipelined square root, two pipelined dividers, sign and clipping.
// Depends on qrs_pkg and qrs_if.
module qrs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  qrs_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_ready,
	qrs_out_if.source     roots
);
	import qrs_pkg::*;

	typedef struct packed {
		kind_t                 kind;
		logic                  an;
		logic [WORD_BITS-1:0]  am;
		logic                  mbneg;
		logic [WORD_BITS-1:0]  bm;
		logic [RAD_BITS-1:0]   rad;
		logic [SREM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0]  root;
	} sq_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  an;
		logic                  n1neg;
		logic                  n2neg;
		logic [DEN_BITS-1:0]   den;
		logic [QUO_BITS-1:0]   num1;
		logic [QUO_BITS-1:0]   num2;
		logic [QUO_BITS-1:0]   q1;
		logic [QUO_BITS-1:0]   q2;
		logic [DREM_BITS-1:0]  r1;
		logic [DREM_BITS-1:0]  r2;
	} dv_t;

	logic adv;
	logic [ROOT_BITS:0] sqv_s;
	logic [QUO_BITS:0]  dvv_s;
	sq_t  sq_s [ROOT_BITS+1];
	sq_t  sq_nx [ROOT_BITS];
	dv_t  dv_s [QUO_BITS+1];
	dv_t  dv_nx [QUO_BITS];
	dv_t  dv_in;
	fin_t f1, f2;

	logic                 out_v_q, sat_q;
	logic [1:0]           kind_q;
	logic [WORD_BITS-1:0] first_q, second_q;

	assign adv       = !out_v_q || roots.ready;
	assign job_ready = adv;

	assign roots.valid        = out_v_q;
	assign roots.root_kind    = kind_q;
	assign roots.first_value  = first_q;
	assign roots.second_value = second_q;
	assign roots.saturated    = sat_q;

	// One root bit per stage.
	always_comb begin
		logic [SREM_BITS-1:0] cur, trial;
		for (int k = 0; k < ROOT_BITS; k++) begin
			sq_nx[k] = sq_s[k];
			cur   = {sq_s[k].rem[SREM_BITS-3:0], sq_s[k].rad[RAD_BITS-1:RAD_BITS-2]};
			trial = SREM_BITS'({sq_s[k].root, 2'b01});
			sq_nx[k].rad = {sq_s[k].rad[RAD_BITS-3:0], 2'b00};
			if (cur >= trial) begin
				sq_nx[k].rem  = cur - trial;
				sq_nx[k].root = {sq_s[k].root[ROOT_BITS-2:0], 1'b1};
			end else begin
				sq_nx[k].rem  = cur;
				sq_nx[k].root = {sq_s[k].root[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	// Numerators for the two quotients, chosen by kind.
	always_comb begin
		sm_t n1, n2, mb;
		sq_t t;
		t  = sq_s[ROOT_BITS];
		mb.neg = t.mbneg;
		mb.mag = NUM_BITS'(t.bm);
		case (t.kind)
			KIND_DISTINCT: begin
				n1 = sm_add(t.mbneg, NUM_BITS'(t.bm), 1'b0, NUM_BITS'(t.root));
				n2 = sm_add(t.mbneg, NUM_BITS'(t.bm), 1'b1, NUM_BITS'(t.root));
			end
			KIND_COMPLEX: begin
				n1 = mb;
				n2.neg = 1'b0;
				n2.mag = NUM_BITS'(t.root);
			end
			default: begin
				n1 = mb;
				n2 = mb;
			end
		endcase
		dv_in.kind  = t.kind;
		dv_in.an    = t.an;
		dv_in.n1neg = n1.neg;
		dv_in.n2neg = n2.neg;
		dv_in.den   = {t.am, 1'b0};
		dv_in.num1  = {n1.mag, {FRAC_BITS{1'b0}}};
		dv_in.num2  = {n2.mag, {FRAC_BITS{1'b0}}};
		dv_in.q1    = '0;
		dv_in.q2    = '0;
		dv_in.r1    = '0;
		dv_in.r2    = '0;
	end

	// One quotient bit per stage in each divider.
	always_comb begin
		logic [DREM_BITS-1:0] c1, c2, dx;
		for (int k = 0; k < QUO_BITS; k++) begin
			dv_nx[k] = dv_s[k];
			dx = DREM_BITS'(dv_s[k].den);
			c1 = {dv_s[k].r1[DREM_BITS-2:0], dv_s[k].num1[QUO_BITS-1]};
			c2 = {dv_s[k].r2[DREM_BITS-2:0], dv_s[k].num2[QUO_BITS-1]};
			dv_nx[k].num1 = {dv_s[k].num1[QUO_BITS-2:0], 1'b0};
			dv_nx[k].num2 = {dv_s[k].num2[QUO_BITS-2:0], 1'b0};
			if (c1 >= dx) begin
				dv_nx[k].r1 = c1 - dx;
				dv_nx[k].q1 = {dv_s[k].q1[QUO_BITS-2:0], 1'b1};
			end else begin
				dv_nx[k].r1 = c1;
				dv_nx[k].q1 = {dv_s[k].q1[QUO_BITS-2:0], 1'b0};
			end
			if (c2 >= dx) begin
				dv_nx[k].r2 = c2 - dx;
				dv_nx[k].q2 = {dv_s[k].q2[QUO_BITS-2:0], 1'b1};
			end else begin
				dv_nx[k].r2 = c2;
				dv_nx[k].q2 = {dv_s[k].q2[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	assign f1 = finish(dv_s[QUO_BITS].q1, dv_s[QUO_BITS].n1neg, dv_s[QUO_BITS].an);
	assign f2 = finish(dv_s[QUO_BITS].q2, dv_s[QUO_BITS].n2neg, dv_s[QUO_BITS].an);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s   <= '0;
			dvv_s   <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			sqv_s   <= {sqv_s[ROOT_BITS-1:0], job_valid};
			dvv_s   <= {dvv_s[QUO_BITS-1:0], sqv_s[ROOT_BITS]};
			out_v_q <= dvv_s[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].kind  <= job.kind;
			sq_s[0].an    <= job.an;
			sq_s[0].am    <= job.am;
			sq_s[0].mbneg <= job.mbneg;
			sq_s[0].bm    <= job.bm;
			sq_s[0].rad   <= RAD_BITS'(job.dmag);
			sq_s[0].rem   <= '0;
			sq_s[0].root  <= '0;
			for (int k = 0; k < ROOT_BITS; k++) sq_s[k+1] <= sq_nx[k];
			dv_s[0] <= dv_in;
			for (int k = 0; k < QUO_BITS; k++) dv_s[k+1] <= dv_nx[k];
			kind_q <= dv_s[QUO_BITS].kind;
			if (dv_s[QUO_BITS].kind == KIND_DEGEN) begin
				first_q  <= '0;
				second_q <= '0;
				sat_q    <= 1'b0;
			end else begin
				first_q  <= f1.val;
				second_q <= f2.val;
				sat_q    <= f1.sat || f2.sat;
			end
		end
	end

endmodule

// ===== rtl/quadratic_root_solver_top.sv =====
// Pipeline: front-end registers s1 to s3, the queue, WORD_BITS+2 square-root stages,
// WORD_BITS+FRAC_BITS+3 divider stages and the output register.
// Throughput: one word per cycle unless stalled; root and both dividers fully pipelined.
// Reset: arst_n clears all valid bits and queue pointers at once; data is not cleared.
// Depends on qrs_pkg, qrs_if, qrs_front, qrs_fifo and qrs_back.
module quadratic_root_solver_top (
	input  logic      clk,
	input  logic      arst_n,
	qrs_in_if.sink    coeffs,
	qrs_out_if.source roots
);
	import qrs_pkg::*;

	// The front end classifies each word and the back end solves it; the queue
	// between them lets the multiplier stages keep taking words while the
	// back end waits on a stalled output, and vice versa.
	job_t f_job, b_job;
	logic f_valid, f_ready, b_valid, b_ready;

	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coeffs    (coeffs),
		.job       (f_job),
		.job_valid (f_valid),
		.job_ready (f_ready)
	);

	qrs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (f_job),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_data   (b_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	// The back end holds every stage while its output word waits to be taken.
	qrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (b_job),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.roots     (roots)
	);

endmodule

// ===== rtl/qrs_checker.sv =====
// Port-level checks on the result channel of the quadratic root solver, and their bind.
// Depends on qrs_pkg and quadratic_root_solver_top.
module qrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    root_kind,
	input logic [qrs_pkg::WORD_BITS-1:0] first_value,
	input logic [qrs_pkg::WORD_BITS-1:0] second_value,
	input logic                          saturated
);
	import qrs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_value) &&
		$stable(second_value) && $stable(root_kind) && $stable(saturated))
		else $error("result word changed while stalled");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_DEGEN |->
		first_value == '0 && second_value == '0 && !saturated)
		else $error("degenerate result carries nonzero fields");

	a_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_REPEATED |-> first_value == second_value)
		else $error("repeated root values differ");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
		first_value == WORD_MAX || first_value == WORD_MIN ||
		second_value == WORD_MAX || second_value == WORD_MIN)
		else $error("saturated flag without a clipped value");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (roots.valid),
	.out_ready    (roots.ready),
	.root_kind    (roots.root_kind),
	.first_value  (roots.first_value),
	.second_value (roots.second_value),
	.saturated    (roots.saturated)
);

// ===== bench/quadratic_root_solver_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the quadratic root solver: words of coefficients go in,
// root words are predicted in the bench and compared. Depends on qrs_pkg, qrs_if, the top.
module quadratic_root_solver_top_tb;
	import qrs_pkg::*;

	typedef struct {
		logic signed [WORD_BITS-1:0] a;
		logic signed [WORD_BITS-1:0] b;
		logic signed [WORD_BITS-1:0] c;
	} coeff_word_t;

	typedef struct {
		kind_t                kind;
		logic [WORD_BITS-1:0] first;
		logic [WORD_BITS-1:0] second;
		logic                 sat;
	} root_word_t;

	typedef struct {
		logic [WORD_BITS-1:0] val;
		logic                 sat;
	} clip_t;

	logic clk;
	logic arst_n;

	qrs_in_if  coeffs_if ();
	qrs_out_if roots_if ();

	quadratic_root_solver_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.coeffs (coeffs_if.sink),
		.roots  (roots_if.source)
	);

	coeff_word_t pending_coeffs[$];
	root_word_t  expected_roots[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          failures;
	logic        in_taken;

	// Floor of the square root of a wide unsigned value, one result bit per pass.
	function automatic logic [127:0] isqrt_wide(input logic [127:0] n);
		logic [127:0] res;
		logic [127:0] one;
		logic [127:0] t;
		res = '0;
		one = 128'd1 << 126;
		while (one > n)
			one = one >> 2;
		while (one != 0) begin
			t = res + one;
			if (n >= t) begin
				n   = n - t;
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	// Numerator times 2^FRAC_BITS over 2a, truncated toward zero, clipped to a word.
	function automatic clip_t scale_over_2a(input logic signed [129:0] num, input logic an,
			input logic [WORD_BITS-1:0] am);
		logic [129:0] mag;
		logic [129:0] q;
		logic         neg;
		clip_t        r;
		mag   = num[129] ? -num : num;
		q     = (mag << FRAC_BITS) / (130'(am) << 1);
		neg   = (num[129] != an) && (q != 0);
		r.sat = 1'b0;
		if (neg) begin
			if (q > (130'd1 << (WORD_BITS - 1))) begin
				r.val = WORD_MIN;
				r.sat = 1'b1;
			end else begin
				r.val = WORD_BITS'(-q);
			end
		end else if (q > (130'd1 << (WORD_BITS - 1)) - 1) begin
			r.val = WORD_MAX;
			r.sat = 1'b1;
		end else begin
			r.val = q[WORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic root_word_t solve_roots(input coeff_word_t w);
		logic [WORD_BITS-1:0]  am;
		logic [WORD_BITS-1:0]  bm;
		logic [WORD_BITS-1:0]  cm;
		logic [127:0]          b2;
		logic [127:0]          ac4;
		logic signed [129:0]   disc;
		logic signed [129:0]   bx;
		logic signed [129:0]   nb;
		logic signed [129:0]   sx;
		clip_t                 r1;
		clip_t                 r2;
		root_word_t            r;
		am = w.a[WORD_BITS-1] ? ~w.a + 1'b1 : w.a;
		bm = w.b[WORD_BITS-1] ? ~w.b + 1'b1 : w.b;
		cm = w.c[WORD_BITS-1] ? ~w.c + 1'b1 : w.c;
		if (am == 0) begin
			r.kind   = KIND_DEGEN;
			r.first  = '0;
			r.second = '0;
			r.sat    = 1'b0;
			return r;
		end
		b2  = 128'(bm) * 128'(bm);
		ac4 = (128'(am) * 128'(cm)) << 2;
		// The 4ac term is subtracted when a and c share a sign.
		if (w.a[WORD_BITS-1] == w.c[WORD_BITS-1])
			disc = $signed({2'b00, b2}) - $signed({2'b00, ac4});
		else
			disc = $signed({2'b00, b2}) + $signed({2'b00, ac4});
		bx = w.b;
		nb = -bx;
		sx = $signed({2'b00, isqrt_wide(disc[129] ? 128'(-disc) : 128'(disc))});
		if (disc == 0) begin
			r.kind = KIND_REPEATED;
			r1 = scale_over_2a(nb, w.a[WORD_BITS-1], am);
			r2 = r1;
		end else if (!disc[129]) begin
			r.kind = KIND_DISTINCT;
			r1 = scale_over_2a(nb + sx, w.a[WORD_BITS-1], am);
			r2 = scale_over_2a(nb - sx, w.a[WORD_BITS-1], am);
		end else begin
			r.kind = KIND_COMPLEX;
			r1 = scale_over_2a(nb, w.a[WORD_BITS-1], am);
			r2 = scale_over_2a(sx, w.a[WORD_BITS-1], am);
		end
		r.first  = r1.val;
		r.second = r2.val;
		r.sat    = r1.sat | r2.sat;
		return r;
	endfunction

	task automatic queue_coeffs(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		coeff_word_t w;
		w.a = a;
		w.b = b;
		w.c = c;
		pending_coeffs.push_back(w);
	endtask

	// A value spread over many magnitudes, so that both small and full-range codes appear.
	function automatic logic [31:0] spread_value();
		logic [31:0] v;
		int          sh;
		v  = $urandom;
		sh = $urandom_range(0, 31);
		if ($urandom_range(0, 1))
			v = $signed(v) >>> sh;
		return v;
	endfunction

	// Random equations: mostly wide-ranging codes, some exact repeated roots, some a zero.
	task automatic queue_random(input int count);
		int          i;
		int          k;
		int          m;
		logic [31:0] a;
		for (i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					// b*b equals 4ac exactly: a = k, b = 2km, c = km^2.
					k = $urandom_range(1, 300);
					m = $urandom_range(0, 300);
					if ($urandom_range(0, 1))
						m = -m;
					a = k;
					if ($urandom_range(0, 1)) begin
						queue_coeffs(-a, -(2 * k * m), -(k * m * m));
					end else begin
						queue_coeffs(a, 2 * k * m, k * m * m);
					end
				end
				1:
					queue_coeffs('0, $urandom, $urandom);
				2:
					queue_coeffs($urandom, $urandom, $urandom);
				default:
					queue_coeffs(spread_value(), spread_value(), spread_value());
			endcase
		end
	endtask

	task automatic wait_drained();
		while (pending_coeffs.size() != 0 || coeffs_if.valid || expected_roots.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The sender holds a word until it is taken, then either idles or offers the next.
	always @(posedge clk)
		in_taken <= coeffs_if.valid && coeffs_if.ready;

	always @(negedge clk) begin
		if (!arst_n) begin
			coeffs_if.valid <= 1'b0;
		end else if (!coeffs_if.valid || in_taken) begin
			if (pending_coeffs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				coeffs_if.valid   <= 1'b1;
				coeffs_if.coeff_a <= pending_coeffs[0].a;
				coeffs_if.coeff_b <= pending_coeffs[0].b;
				coeffs_if.coeff_c <= pending_coeffs[0].c;
				pending_coeffs.pop_front();
			end else begin
				coeffs_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		roots_if.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);

	// Each accepted word of coefficients gets its roots predicted at once.
	always @(posedge clk) begin
		coeff_word_t w;
		if (arst_n && coeffs_if.valid && coeffs_if.ready) begin
			w.a = coeffs_if.coeff_a;
			w.b = coeffs_if.coeff_b;
			w.c = coeffs_if.coeff_c;
			expected_roots.push_back(solve_roots(w));
		end
	end

	// Each root word leaving the block is matched against the oldest prediction.
	always @(posedge clk) begin
		root_word_t e;
		if (arst_n && roots_if.valid && roots_if.ready) begin
			if (expected_roots.size() == 0) begin
				$error("root word with no prediction waiting");
				failures++;
			end else begin
				e = expected_roots.pop_front();
				if (roots_if.root_kind !== e.kind) begin
					$error("root_kind expected %0d actual %0d", e.kind, roots_if.root_kind);
					failures++;
				end
				if (roots_if.first_value !== e.first) begin
					$error("first_value expected %h actual %h", e.first,
						roots_if.first_value);
					failures++;
				end
				if (roots_if.second_value !== e.second) begin
					$error("second_value expected %h actual %h", e.second,
						roots_if.second_value);
					failures++;
				end
				if (roots_if.saturated !== e.sat) begin
					$error("saturated expected %0b actual %0b", e.sat, roots_if.saturated);
					failures++;
				end
			end
		end
	end

	initial begin
		failures          = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		in_taken          = 1'b0;
		coeffs_if.valid   = 1'b0;
		coeffs_if.coeff_a = '0;
		coeffs_if.coeff_b = '0;
		coeffs_if.coeff_c = '0;
		roots_if.ready    = 1'b0;
		arst_n            = 1'b0;
		repeat (6) @(posedge clk);
		arst_n = 1'b1;

		// Directed words: a zero, repeated, distinct and complex roots, extremes, clipping.
		queue_coeffs(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
		queue_coeffs(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
		queue_coeffs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
		queue_coeffs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
		queue_coeffs(32'hffff_ffff, 32'h0000_0002, 32'hffff_ffff);
		queue_coeffs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
		queue_coeffs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
		queue_coeffs(32'hffff_0000, 32'h0000_0000, 32'h0001_0000);
		queue_coeffs(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		queue_coeffs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		queue_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_coeffs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		queue_coeffs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		queue_coeffs(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000);
		queue_coeffs(32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
		queue_coeffs(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		queue_coeffs(32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff);
		queue_coeffs(32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
		queue_coeffs(32'h0000_0001, 32'h0001_0000, 32'h0000_0000);
		queue_coeffs(32'h0001_0000, 32'h0000_0001, 32'h0000_0000);
		queue_coeffs(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		queue_coeffs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		wait_drained();

		// Random words over four idling mixes; the wait between mixes lets the
		// sender pause until every predicted root word has come back.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random(200);
		wait_drained();
		send_idle_pct = 63;
		queue_random(210);
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 63;
		queue_random(210);
		wait_drained();
		send_idle_pct  = 6;
		recv_stall_pct = 6;
		queue_random(210);
		wait_drained();

		repeat (150) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== quadratic_root_solver_top.f =====
rtl/qrs_pkg.sv
rtl/qrs_if.sv
rtl/qrs_front.sv
rtl/qrs_fifo.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver_top.sv
rtl/qrs_checker.sv
bench/quadratic_root_solver_top_tb.sv
